// ===== rtl/pfcq_pkg.sv =====
// ----------------------------------------------------------------------------
// pfcq_pkg
// Shared constants and types of the payload framer with CRC queue.
// ----------------------------------------------------------------------------
package pfcq_pkg;

  localparam int unsigned QueueDepthDefault = 4;
  localparam int unsigned MaxPayloadDefault = 256;
  localparam int unsigned HdrLen = 16;
  localparam logic [7:0] HdrLenByte = 8'd14;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam logic [1:0] CMD_PUSH    = 2'd0;
  localparam logic [1:0] CMD_FETCH   = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DROPPED  = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_ABORTED  = 3'd3;
  localparam logic [2:0] ST_DISABLED = 3'd4;

  localparam logic [2:0] REG_ENABLED  = 3'd0;
  localparam logic [2:0] REG_PAYLOAD  = 3'd1;
  localparam logic [2:0] REG_CHANMASK = 3'd2;
  localparam logic [2:0] REG_START    = 3'd3;
  localparam logic [2:0] REG_SYNC0    = 3'd4;
  localparam logic [2:0] REG_SYNC1    = 3'd5;
  localparam logic [2:0] REG_VERSION  = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic push;      // accept a payload byte
    logic fetch;     // produce the next frame byte
    logic release_cs;
    logic dis_push;  // disabled push: bit counter and fill count only
    logic take;      // latch an item into the working registers
  } pfcq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic enabled;
  } pfcq_stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== rtl/pfcq_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfcq_ctrl
// Sequencer: takes an item, runs its read and update cycles, then holds the
// result until the receiver takes the beat.
// ----------------------------------------------------------------------------
module pfcq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           command,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  pfcq_pkg::pfcq_stat_t stat,
  output pfcq_pkg::pfcq_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [1:0] op;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_EXEC;
      S_EXEC:  state_next = S_OUT;
      S_OUT:   if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= pfcq_pkg::CMD_NONE;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_valid) op <= command;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.take = (state == S_IDLE) && in_valid;
    if (state == S_EXEC) begin
      cmd.push       = stat.enabled && (op == pfcq_pkg::CMD_PUSH);
      cmd.fetch      = stat.enabled && (op == pfcq_pkg::CMD_FETCH);
      cmd.release_cs = stat.enabled && (op == pfcq_pkg::CMD_RELEASE);
      cmd.dis_push   = !stat.enabled && (op == pfcq_pkg::CMD_PUSH);
    end
  end

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> !cmd.take) else $error("item taken while busy");
  a_exec_to_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |=> out_valid) else $error("result not shown after work");
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.push, cmd.fetch, cmd.release_cs, cmd.dis_push}))
    else $error("several operations at once");
`endif

endmodule

// ===== rtl/pfcq_dp.sv =====
// ----------------------------------------------------------------------------
// pfcq_dp
// Datapath: registers, frame ring, payload memory, header mux and CRC.
// ----------------------------------------------------------------------------
module pfcq_dp #(
  parameter int unsigned QUEUE_DEPTH = pfcq_pkg::QueueDepthDefault,
  parameter int unsigned MAX_PAYLOAD = pfcq_pkg::MaxPayloadDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic [1:0]           command,
  input  logic [7:0]           data_byte,
  input  pfcq_pkg::pfcq_cmd_t  cmd,
  output pfcq_pkg::pfcq_stat_t stat,
  output logic [2:0]           status,
  output logic [7:0]           tx_byte,
  output logic                 last_of_frame,
  output logic [2:0]           queued_frames
);

  localparam int unsigned SW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned PW = $clog2(MAX_PAYLOAD);
  localparam int unsigned FW = PW + 1;               // holds MAX_PAYLOAD
  localparam int unsigned TW = $clog2(MAX_PAYLOAD + pfcq_pkg::HdrLen + 2);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW = SW + PW;

  // Configuration registers.
  logic        enabled;
  logic [8:0]  frame_bytes;
  logic [7:0]  hdr_mask, sync_first, sync_second, protocol_version;

  logic [7:0]  pl_mem [QUEUE_DEPTH * MAX_PAYLOAD];
  logic [63:0] slot_start_bits [QUEUE_DEPTH];
  logic [1:0]  slot_flags [QUEUE_DEPTH];
  logic [SW-1:0] write_slot, read_slot;
  logic [CW-1:0] frame_total;
  logic [FW-1:0] fill_count;
  logic [63:0] bit_counter, pending_start;
  logic [1:0]  sticky_bits;
  logic        dropping;
  logic [TW-1:0] tx_position;
  logic [15:0] tx_crc;
  logic [7:0]  mem_q;
  logic [7:0]  item_data;

  logic [FW-1:0] size;
  logic [TW-1:0] end_pos;
  logic          start_frame, drop_now, finish;
  logic [FW-1:0] fill_inc;
  logic [7:0]    hdr, tx_sel;
  logic [3:0]    hpos;
  logic [2:0]    bsel;
  logic [SW-1:0] read_slot_inc, write_slot_inc;

  always_comb begin
    if (frame_bytes == 9'd0 || {23'd0, frame_bytes} > 32'(MAX_PAYLOAD))
      size = FW'(MAX_PAYLOAD);
    else
      size = FW'(frame_bytes);
  end

  assign end_pos        = TW'(pfcq_pkg::HdrLen) + TW'(size);
  assign start_frame    = (fill_count == '0);
  assign drop_now       = start_frame ? (frame_total >= CW'(QUEUE_DEPTH)) : dropping;
  assign fill_inc       = fill_count + 1'b1;
  assign finish         = fill_inc >= size;
  assign read_slot_inc  = (read_slot == SW'(QUEUE_DEPTH - 1)) ? '0 : read_slot + 1'b1;
  assign write_slot_inc = (write_slot == SW'(QUEUE_DEPTH - 1)) ? '0 : write_slot + 1'b1;
  assign stat.enabled   = enabled;

  assign hpos = tx_position[3:0];
  assign bsel = 3'(hpos - 4'd4);
  always_comb begin
    case (hpos)
      4'd0:    hdr = sync_first;
      4'd1:    hdr = sync_second;
      4'd2:    hdr = protocol_version;
      4'd3:    hdr = pfcq_pkg::HdrLenByte;
      4'd12:   hdr = {6'd0, slot_flags[read_slot]};
      4'd13:   hdr = hdr_mask;
      4'd14:   hdr = 8'(size);
      4'd15:   hdr = 8'(size >> 8);
      default: hdr = slot_start_bits[read_slot][{bsel, 3'b000} +: 8];
    endcase
  end

  always_comb begin
    if (tx_position < TW'(pfcq_pkg::HdrLen)) tx_sel = hdr;
    else if (tx_position < end_pos)          tx_sel = mem_q;
    else if (tx_position == end_pos)         tx_sel = tx_crc[7:0];
    else                                     tx_sel = tx_crc[15:8];
  end

  // Payload memory: the read address is set up while the item is taken.
  logic [TW-1:0] pl_off;
  assign pl_off = tx_position - TW'(pfcq_pkg::HdrLen);
  always_ff @(posedge clk) begin
    if (cmd.take) mem_q <= pl_mem[{read_slot, pl_off[PW-1:0]}];
    if (cmd.push && !drop_now && fill_count < FW'(MAX_PAYLOAD))
      pl_mem[AW'({write_slot, fill_count[PW-1:0]})] <= item_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.take) item_data <= data_byte;
  end

  always_ff @(posedge clk) begin
    if (cmd.push && finish && !drop_now) begin
      slot_start_bits[write_slot] <= start_frame ? bit_counter : pending_start;
      slot_flags[write_slot] <= sticky_bits | {1'b0, drop_now};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0; frame_bytes <= 9'd256; hdr_mask <= '0;
      sync_first <= '0; sync_second <= '0; protocol_version <= '0;
      write_slot <= '0; read_slot <= '0; frame_total <= '0; fill_count <= '0;
      bit_counter <= '0; pending_start <= '0; sticky_bits <= '0; dropping <= 1'b0;
      tx_position <= '0; tx_crc <= pfcq_pkg::CrcInit;
      status <= pfcq_pkg::ST_OK; tx_byte <= '0; last_of_frame <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pfcq_pkg::REG_ENABLED: if (cfg_data[0] != enabled) begin
            enabled <= cfg_data[0];
            write_slot <= '0; read_slot <= '0; frame_total <= '0; fill_count <= '0;
            pending_start <= bit_counter; sticky_bits <= '0; dropping <= 1'b0;
            tx_position <= '0; tx_crc <= pfcq_pkg::CrcInit;
          end
          pfcq_pkg::REG_PAYLOAD:  frame_bytes <= cfg_data[8:0];
          pfcq_pkg::REG_CHANMASK: hdr_mask <= cfg_data[7:0];
          pfcq_pkg::REG_START: begin
            bit_counter <= cfg_data; pending_start <= cfg_data;
          end
          pfcq_pkg::REG_SYNC0:   sync_first <= cfg_data[7:0];
          pfcq_pkg::REG_SYNC1:   sync_second <= cfg_data[7:0];
          pfcq_pkg::REG_VERSION: protocol_version <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (cmd.take) begin
        status <= (command != pfcq_pkg::CMD_NONE && !enabled) ? pfcq_pkg::ST_DISABLED
                                                              : pfcq_pkg::ST_OK;
        tx_byte <= '0; last_of_frame <= 1'b0;
      end
      if (cmd.dis_push) begin
        bit_counter <= bit_counter + 64'd8; fill_count <= '0;
      end
      if (cmd.push) begin
        bit_counter <= bit_counter + 64'd8;
        if (start_frame) pending_start <= bit_counter;
        if (drop_now) status <= pfcq_pkg::ST_DROPPED;
        if (finish) begin
          fill_count <= '0; dropping <= 1'b0;
          if (!drop_now) begin
            sticky_bits <= '0; write_slot <= write_slot_inc;
            frame_total <= frame_total + 1'b1;
          end else if (start_frame) begin
            sticky_bits <= sticky_bits | 2'b01;
          end
        end else begin
          fill_count <= fill_inc; dropping <= drop_now;
          if (start_frame && drop_now) sticky_bits <= sticky_bits | 2'b01;
        end
      end
      if (cmd.release_cs && tx_position != '0 && frame_total != '0) begin
        read_slot <= read_slot_inc; frame_total <= frame_total - 1'b1;
        tx_position <= '0; tx_crc <= pfcq_pkg::CrcInit;
        sticky_bits <= sticky_bits | 2'b10; status <= pfcq_pkg::ST_ABORTED;
      end
      if (cmd.fetch) begin
        if (frame_total == '0) begin
          status <= pfcq_pkg::ST_EMPTY;
        end else begin
          tx_byte <= tx_sel;
          if (tx_position >= TW'(2) && tx_position < end_pos)
            tx_crc <= pfcq_pkg::crc_byte(tx_crc, tx_sel);
          if (tx_position > end_pos) begin
            last_of_frame <= 1'b1; read_slot <= read_slot_inc;
            frame_total <= frame_total - 1'b1;
            tx_position <= '0; tx_crc <= pfcq_pkg::CrcInit;
          end else begin
            tx_position <= tx_position + 1'b1;
          end
        end
      end
    end
  end

  assign queued_frames = 3'(frame_total);

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    frame_total <= CW'(QUEUE_DEPTH)) else $error("ring count beyond depth");
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.fetch && frame_total != '0 && tx_position > end_pos) |=> tx_position == '0)
    else $error("frame end did not reset position");
  a_crc_idle: assert property (@(posedge clk) disable iff (rst)
    (tx_position == '0) |-> tx_crc == pfcq_pkg::CrcInit) else $error("crc not at init");
`endif

endmodule

// ===== rtl/payload_framer_crc_queue.sv =====
// ----------------------------------------------------------------------------
// payload_framer_crc_queue
// Cuts payload bytes into frames, queues them and sends them with a CRC.
// ----------------------------------------------------------------------------
// Each input beat carries a command (push byte, fetch transmit byte or
// chip-select release) and a data byte; each yields exactly one output beat
// with status, tx_byte, last_of_frame and queued_frames.
// An item is latched in the idle state, which also starts the payload memory
// read; the framer state is updated in the execute state, and the result is
// shown in the output state. The memory read port and the single state update
// per item mean that the input takes no new beat until the last result is taken.
// While the output beat is stalled the input stays stalled too.
// After reset framing is disabled, the queue is empty and the payload size
// is 256 bytes. Configuration writes take effect at once on the write port;
// the user must make them only while no item is in progress; the block does not enforce it.
// ----------------------------------------------------------------------------
module payload_framer_crc_queue #(
  parameter int unsigned QUEUE_DEPTH = pfcq_pkg::QueueDepthDefault,
  parameter int unsigned MAX_PAYLOAD = pfcq_pkg::MaxPayloadDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  tx_byte,
  output logic        last_of_frame,
  output logic [2:0]  queued_frames
);

  pfcq_pkg::pfcq_cmd_t  cmd;
  pfcq_pkg::pfcq_stat_t stat;

  pfcq_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .command, .out_valid, .out_stall,
    .stat, .cmd
  );

  pfcq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .MAX_PAYLOAD(MAX_PAYLOAD)) u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .command, .data_byte,
    .cmd, .stat, .status, .tx_byte, .last_of_frame, .queued_frames
  );

endmodule
